[rtl/core/pdga_pkg.sv]
`default_nettype none

package pdga_pkg;

  localparam int unsigned COORD_W    = 15;
  localparam int unsigned RADSQ_W    = 25;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ADDR_OUT_W = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned SQ_W       = 2 * COORD_W;
  localparam int unsigned SUM_W      = SQ_W + 2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CLOSE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ = 3'd3;

  localparam logic [COORD_W-1:0] EXTENT_RST = 15'h7FFF;
  localparam logic [RADSQ_W-1:0] RADSQ_RST  = 25'd3145728;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic   vld;
    point_t pt;
  } entry_t;

  // control from the sequencer to the distance pipe
  typedef struct packed {
    logic clr;
    logic vld;
  } dist_ctl_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[rtl/core/pdga_grid_mem.sv]
`default_nettype none

module pdga_grid_mem #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15,
  parameter int unsigned DW    = 46
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/pdga_dist.sv]
`default_nettype none

module pdga_dist (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire pdga_pkg::dist_ctl_t                ctl,
  input  wire pdga_pkg::entry_t                   rd_entry,
  input  wire pdga_pkg::point_t                   cand,
  input  wire logic [pdga_pkg::RADSQ_W-1:0]       radius_sq,
  output logic                                    too_close
);

  logic [pdga_pkg::COORD_W-1:0] dx, dy, dz;
  logic [pdga_pkg::SQ_W-1:0]    sqx_r, sqy_r, sqz_r;
  logic                         sq_vld_r;
  logic                         sq_vld_nxt;
  logic [pdga_pkg::SUM_W-1:0]   sum;
  logic                         hit;
  logic                         acc_r;
  logic                         acc_nxt;

  always_comb begin
    dx = (rd_entry.pt.x >= cand.x) ? rd_entry.pt.x - cand.x : cand.x - rd_entry.pt.x;
    dy = (rd_entry.pt.y >= cand.y) ? rd_entry.pt.y - cand.y : cand.y - rd_entry.pt.y;
    dz = (rd_entry.pt.z >= cand.z) ? rd_entry.pt.z - cand.z : cand.z - rd_entry.pt.z;
    sq_vld_nxt = ctl.vld & rd_entry.vld;
  end

  // stage 1: squares
  always_ff @(posedge clk) begin
    sqx_r <= pdga_pkg::SQ_W'(dx) * pdga_pkg::SQ_W'(dx);
    sqy_r <= pdga_pkg::SQ_W'(dy) * pdga_pkg::SQ_W'(dy);
    sqz_r <= pdga_pkg::SQ_W'(dz) * pdga_pkg::SQ_W'(dz);
  end

  // stage 2: sum, compare, sticky hit
  always_comb begin
    sum = pdga_pkg::SUM_W'(sqx_r) + pdga_pkg::SUM_W'(sqy_r) + pdga_pkg::SUM_W'(sqz_r);
    hit = sq_vld_r && (sum < pdga_pkg::SUM_W'(radius_sq));
    acc_nxt = ctl.clr ? 1'b0 : (acc_r | hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      acc_r    <= 1'b0;
    end else begin
      sq_vld_r <= sq_vld_nxt;
      acc_r    <= acc_nxt;
    end
  end

  assign too_close = acc_r;

endmodule

`default_nettype wire

[rtl/core/poisson_disk_grid_accept_unit.sv]
`default_nettype none

// Poisson-disk grid acceptance unit (3D background grid).
// Input channel: a word is taken when start is high and busy is low. cmd 0 tests
// the candidate (cand_x/y/z) against the stored points of the clamped 5x5x5
// cell block and stores it in its cell when nothing is closer than the radius;
// cmd 1 empties the grid.
// Result channel: out_valid is high for one cycle with out_status and
// out_cell_addr; there is no back-pressure, the receiver must take it.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write registers only while the unit is idle.
// Timing: an out-of-extent candidate reports in the cycle after it is taken. A test
// reads N neighbor cells (N up to 125), one per cycle through the single port of
// the grid memory, then drains the read and distance pipe and decides; busy
// falls in the result cycle.
// A clear sweeps all GRID_X*GRID_Y*GRID_Z cells (32768 at the default size) of
// the grid memory one cell per cycle, and reports in the cycle after the sweep ends.
// Reset runs the same sweep without a result; busy stays high until it is done.
module poisson_disk_grid_accept_unit #(
  parameter int unsigned GRID_X    = 32,
  parameter int unsigned GRID_Y    = 32,
  parameter int unsigned GRID_Z    = 32,
  parameter int unsigned FRAC_BITS = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_cmd,
  input  wire logic [pdga_pkg::COORD_W-1:0]         in_cand_x,
  input  wire logic [pdga_pkg::COORD_W-1:0]         in_cand_y,
  input  wire logic [pdga_pkg::COORD_W-1:0]         in_cand_z,
  output logic                                      out_valid,
  output logic [pdga_pkg::STATUS_W-1:0]             out_status,
  output logic [pdga_pkg::ADDR_OUT_W-1:0]           out_cell_addr,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pdga_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pdga_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned NCELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned GXY    = GRID_X * GRID_Y;
  localparam int unsigned AW     = $clog2(NCELLS);
  localparam int unsigned XW     = $clog2(GRID_X);
  localparam int unsigned YW     = $clog2(GRID_Y);
  localparam int unsigned ZW     = $clog2(GRID_Z);
  localparam int unsigned DRAIN_CYC = 2;

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic reply_r, reply_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic issue_r;

  logic [XW-1:0] cx_r, cx_nxt, xlo_r, xhi_r;
  logic [YW-1:0] cy_r, cy_nxt, ylo_r, yhi_r;
  logic [ZW-1:0] cz_r, cz_nxt, zlo_r, zhi_r;
  logic [AW-1:0] own_addr_r;
  pdga_pkg::point_t cand_r;

  logic [pdga_pkg::COORD_W-1:0] ext_x_r, ext_y_r, ext_z_r;
  logic [pdga_pkg::RADSQ_W-1:0] radsq_r;

  logic out_valid_r, out_valid_nxt;
  logic [pdga_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [pdga_pkg::ADDR_OUT_W-1:0] out_cell_addr_r, out_cell_addr_nxt;

  logic accept, accept_test;
  logic [31:0] ix_w, iy_w, iz_w, lin_w;
  logic [31:0] xlo_w, xhi_w, ylo_w, yhi_w, zlo_w, zhi_w;
  logic in_ext;

  logic mem_en, mem_we;
  logic [AW-1:0] mem_addr, scan_addr;
  pdga_pkg::entry_t mem_wdata, mem_rdata;
  pdga_pkg::dist_ctl_t dist_ctl;
  logic too_close;

  assign accept      = start && (state_r == ST_IDLE);
  assign accept_test = accept && !in_cmd;

  // candidate decode
  always_comb begin
    ix_w  = 32'(in_cand_x) >> FRAC_BITS;
    iy_w  = 32'(in_cand_y) >> FRAC_BITS;
    iz_w  = 32'(in_cand_z) >> FRAC_BITS;
    lin_w = iz_w * 32'(GXY) + iy_w * 32'(GRID_X) + ix_w;
    in_ext = (in_cand_x < ext_x_r) && (in_cand_y < ext_y_r) && (in_cand_z < ext_z_r) &&
             (ix_w < 32'(GRID_X)) && (iy_w < 32'(GRID_Y)) && (iz_w < 32'(GRID_Z));
    xlo_w = (ix_w < 32'd2) ? 32'd0 : ix_w - 32'd2;
    ylo_w = (iy_w < 32'd2) ? 32'd0 : iy_w - 32'd2;
    zlo_w = (iz_w < 32'd2) ? 32'd0 : iz_w - 32'd2;
    xhi_w = (ix_w + 32'd2 > 32'(GRID_X - 1)) ? 32'(GRID_X - 1) : ix_w + 32'd2;
    yhi_w = (iy_w + 32'd2 > 32'(GRID_Y - 1)) ? 32'(GRID_Y - 1) : iy_w + 32'd2;
    zhi_w = (iz_w + 32'd2 > 32'(GRID_Z - 1)) ? 32'(GRID_Z - 1) : iz_w + 32'd2;
  end

  assign scan_addr = AW'((32'(cz_r) * 32'(GRID_Y) + 32'(cy_r)) * 32'(GRID_X) + 32'(cx_r));

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    sweep_nxt         = sweep_r;
    reply_nxt         = reply_r;
    drain_nxt         = drain_r;
    cx_nxt            = cx_r;
    cy_nxt            = cy_r;
    cz_nxt            = cz_r;
    out_valid_nxt     = 1'b0;
    out_status_nxt    = out_status_r;
    out_cell_addr_nxt = out_cell_addr_r;
    case (state_r)
      ST_SWEEP: begin
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == AW'(NCELLS - 1)) begin
          state_nxt = ST_IDLE;
          if (reply_r) begin
            out_valid_nxt     = 1'b1;
            out_status_nxt    = pdga_pkg::STATUS_OK;
            out_cell_addr_nxt = '0;
          end
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd) begin
            state_nxt = ST_SWEEP;
            sweep_nxt = '0;
            reply_nxt = 1'b1;
          end else begin
            out_cell_addr_nxt = lin_w[pdga_pkg::ADDR_OUT_W-1:0];
            if (in_ext) begin
              state_nxt = ST_SCAN;
              cx_nxt    = XW'(xlo_w);
              cy_nxt    = YW'(ylo_w);
              cz_nxt    = ZW'(zlo_w);
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = pdga_pkg::STATUS_OUTSIDE;
            end
          end
        end
      end
      ST_SCAN: begin
        if (cx_r != xhi_r) begin
          cx_nxt = cx_r + XW'(1);
        end else begin
          cx_nxt = xlo_r;
          if (cy_r != yhi_r) begin
            cy_nxt = cy_r + YW'(1);
          end else begin
            cy_nxt = ylo_r;
            if (cz_r != zhi_r) begin
              cz_nxt = cz_r + ZW'(1);
            end else begin
              state_nxt = ST_DRAIN;
              drain_nxt = 2'(DRAIN_CYC - 1);
            end
          end
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r - 2'd1;
        if (drain_r == 2'd0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt      = ST_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = too_close ? pdga_pkg::STATUS_CLOSE : pdga_pkg::STATUS_OK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      reply_r     <= 1'b0;
      drain_r     <= '0;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
      ext_x_r     <= pdga_pkg::EXTENT_RST;
      ext_y_r     <= pdga_pkg::EXTENT_RST;
      ext_z_r     <= pdga_pkg::EXTENT_RST;
      radsq_r     <= pdga_pkg::RADSQ_RST;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      reply_r     <= reply_nxt;
      drain_r     <= drain_nxt;
      issue_r     <= (state_r == ST_SCAN);
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          pdga_pkg::REG_EXTENT_X:  ext_x_r <= cfg_data[pdga_pkg::COORD_W-1:0];
          pdga_pkg::REG_EXTENT_Y:  ext_y_r <= cfg_data[pdga_pkg::COORD_W-1:0];
          pdga_pkg::REG_EXTENT_Z:  ext_z_r <= cfg_data[pdga_pkg::COORD_W-1:0];
          pdga_pkg::REG_RADIUS_SQ: radsq_r <= cfg_data[pdga_pkg::RADSQ_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cx_r            <= cx_nxt;
    cy_r            <= cy_nxt;
    cz_r            <= cz_nxt;
    out_status_r    <= out_status_nxt;
    out_cell_addr_r <= out_cell_addr_nxt;
    if (accept_test) begin
      cand_r.x   <= in_cand_x;
      cand_r.y   <= in_cand_y;
      cand_r.z   <= in_cand_z;
      own_addr_r <= AW'(lin_w);
      xlo_r      <= XW'(xlo_w);
      xhi_r      <= XW'(xhi_w);
      ylo_r      <= YW'(ylo_w);
      yhi_r      <= YW'(yhi_w);
      zlo_r      <= ZW'(zlo_w);
      zhi_r      <= ZW'(zhi_w);
    end
  end

  // grid port: sweep writes, scan reads, final insert writes
  always_comb begin
    mem_we       = (state_r == ST_SWEEP) || ((state_r == ST_DONE) && !too_close);
    mem_en       = mem_we || (state_r == ST_SCAN);
    mem_addr     = scan_addr;
    mem_wdata.vld = 1'b0;
    mem_wdata.pt  = '0;
    if (state_r == ST_SWEEP) begin
      mem_addr = sweep_r;
    end else if (state_r == ST_DONE) begin
      mem_addr      = own_addr_r;
      mem_wdata.vld = 1'b1;
      mem_wdata.pt  = cand_r;
    end
    dist_ctl.clr = accept_test;
    dist_ctl.vld = issue_r;
  end

  pdga_grid_mem #(
    .DEPTH (NCELLS),
    .AW    (AW),
    .DW    (pdga_pkg::ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  pdga_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (dist_ctl),
    .rd_entry  (mem_rdata),
    .cand      (cand_r),
    .radius_sq (radsq_r),
    .too_close (too_close)
  );

  assign busy          = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_cell_addr = out_cell_addr_r;

  // a word only reports from idle, the end of a sweep or the decision cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_IDLE || $past(state_r) == ST_SWEEP ||
                     $past(state_r) == ST_DONE))
    else $error("result from an unexpected state");

  // grid writes never overlap the neighbor scan or its drain
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_SWEEP || state_r == ST_DONE))
    else $error("grid write outside sweep or insert");

  // a clear word starts a sweep from cell zero
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd) |=> (state_r == ST_SWEEP && sweep_r == '0))
    else $error("clear did not start a sweep");

  // scan counters stay inside the clamped block
  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cx_r >= xlo_r && cx_r <= xhi_r && cy_r >= ylo_r &&
                              cy_r <= yhi_r && cz_r >= zlo_r && cz_r <= zhi_r))
    else $error("scan left the neighbor block");

  // no read results still in flight when the decision is taken
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!issue_r && $past(state_r) == ST_DRAIN))
    else $error("decision before the pipe drained");

endmodule

`default_nettype wire

[bench/tb_poisson_disk_grid_accept_unit.sv]
`timescale 1ns / 100ps

module tb_poisson_disk_grid_accept_unit;

  localparam int GRID_X = 32;
  localparam int GRID_Y = 32;
  localparam int GRID_Z = 32;
  localparam int FRAC_BITS = 10;
  localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;

  localparam logic CMD_TEST  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [pdga_pkg::COORD_W-1:0] COORD_MAX = '1;
  localparam logic [pdga_pkg::RADSQ_W-1:0] RADSQ_MAX = '1;

  localparam int unsigned WATCHDOG_LIMIT = 140000;
  localparam int TAIL_CYCLES = 300;
  localparam int RAND_PHASES = 14;
  localparam int WORDS_PER_PHASE = 125;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [pdga_pkg::STATUS_W-1:0]   status;
    logic [pdga_pkg::ADDR_OUT_W-1:0] addr;
  } verdict_t;

  // Mirror of the background grid: decides every test and clear word in order of acceptance
  // and queues the verdict the block has to report for it.
  class grid_occupancy_model;
    logic [pdga_pkg::COORD_W-1:0] ext_x;
    logic [pdga_pkg::COORD_W-1:0] ext_y;
    logic [pdga_pkg::COORD_W-1:0] ext_z;
    logic [pdga_pkg::RADSQ_W-1:0] min_dist_sq;
    pdga_pkg::point_t             cell_pt [NCELLS];
    bit                           cell_used [NCELLS];
    verdict_t                     pending_verdicts [$];
    int unsigned                  errors;

    function new();
      ext_x = pdga_pkg::EXTENT_RST;
      ext_y = pdga_pkg::EXTENT_RST;
      ext_z = pdga_pkg::EXTENT_RST;
      min_dist_sq = pdga_pkg::RADSQ_RST;
      errors = 0;
      wipe_grid();
    endfunction

    function void wipe_grid();
      foreach (cell_used[i]) cell_used[i] = 1'b0;
    endfunction

    function void set_reg(logic [pdga_pkg::CFG_IDX_W-1:0] idx,
                          logic [pdga_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        pdga_pkg::REG_EXTENT_X:  ext_x = data[pdga_pkg::COORD_W-1:0];
        pdga_pkg::REG_EXTENT_Y:  ext_y = data[pdga_pkg::COORD_W-1:0];
        pdga_pkg::REG_EXTENT_Z:  ext_z = data[pdga_pkg::COORD_W-1:0];
        pdga_pkg::REG_RADIUS_SQ: min_dist_sq = data[pdga_pkg::RADSQ_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned sq_gap(logic [pdga_pkg::COORD_W-1:0] a,
                                     logic [pdga_pkg::COORD_W-1:0] b);
      longint unsigned d;
      d = (a >= b) ? a - b : b - a;
      return d * d;
    endfunction

    task flag(string msg);
      if (errors < MAX_PRINTED) $display("ERROR %0t: %s", $time, msg);
      errors++;
    endtask

    function void take_word(logic cmd, logic [pdga_pkg::COORD_W-1:0] px,
                            logic [pdga_pkg::COORD_W-1:0] py,
                            logic [pdga_pkg::COORD_W-1:0] pz);
      verdict_t v;
      int ix, iy, iz;
      int xlo, xhi, ylo, yhi, zlo, zhi;
      int c;
      bit near;
      longint unsigned d2;
      ix = int'(px >> FRAC_BITS);
      iy = int'(py >> FRAC_BITS);
      iz = int'(pz >> FRAC_BITS);
      if (cmd == CMD_CLEAR) begin
        wipe_grid();
        v.status = pdga_pkg::STATUS_OK;
        v.addr = '0;
      end else begin
        v.addr = pdga_pkg::ADDR_OUT_W'(iz * GRID_X * GRID_Y + iy * GRID_X + ix);
        if (px >= ext_x || py >= ext_y || pz >= ext_z ||
            ix >= GRID_X || iy >= GRID_Y || iz >= GRID_Z) begin
          v.status = pdga_pkg::STATUS_OUTSIDE;
        end else begin
          xlo = (ix < 2) ? 0 : ix - 2;
          ylo = (iy < 2) ? 0 : iy - 2;
          zlo = (iz < 2) ? 0 : iz - 2;
          xhi = (ix + 2 > GRID_X - 1) ? GRID_X - 1 : ix + 2;
          yhi = (iy + 2 > GRID_Y - 1) ? GRID_Y - 1 : iy + 2;
          zhi = (iz + 2 > GRID_Z - 1) ? GRID_Z - 1 : iz + 2;
          near = 1'b0;
          for (int z = zlo; z <= zhi; z++) begin
            for (int y = ylo; y <= yhi; y++) begin
              for (int x = xlo; x <= xhi; x++) begin
                c = (z * GRID_Y + y) * GRID_X + x;
                if (cell_used[c]) begin
                  d2 = sq_gap(cell_pt[c].x, px) + sq_gap(cell_pt[c].y, py)
                     + sq_gap(cell_pt[c].z, pz);
                  // strictly closer than the spacing; equal distance is fine
                  if (d2 < min_dist_sq) near = 1'b1;
                end
              end
            end
          end
          if (near) begin
            v.status = pdga_pkg::STATUS_CLOSE;
          end else begin
            c = (iz * GRID_Y + iy) * GRID_X + ix;
            cell_pt[c] = '{z: pz, y: py, x: px};
            cell_used[c] = 1'b1;
            v.status = pdga_pkg::STATUS_OK;
          end
        end
      end
      pending_verdicts = {pending_verdicts, v};
    endfunction

    task match_result(logic [pdga_pkg::STATUS_W-1:0] status,
                      logic [pdga_pkg::ADDR_OUT_W-1:0] addr);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        flag($sformatf("result with no word pending: status %0d addr %0d", status, addr));
        return;
      end
      v = pending_verdicts.pop_front();
      if (status !== v.status)
        flag($sformatf("status %0d, want %0d (addr %0d)", status, v.status, v.addr));
      if (addr !== v.addr)
        flag($sformatf("cell_addr %0d, want %0d", addr, v.addr));
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic                            in_cmd = 1'b0;
  logic [pdga_pkg::COORD_W-1:0]    in_cand_x = '0;
  logic [pdga_pkg::COORD_W-1:0]    in_cand_y = '0;
  logic [pdga_pkg::COORD_W-1:0]    in_cand_z = '0;
  logic                            out_valid;
  logic [pdga_pkg::STATUS_W-1:0]   out_status;
  logic [pdga_pkg::ADDR_OUT_W-1:0] out_cell_addr;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pdga_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pdga_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  grid_occupancy_model occupancy = new();
  bit                  sender_gaps = 1'b1;
  int unsigned         stall_cycles = 0;

  poisson_disk_grid_accept_unit #(
    .GRID_X    (GRID_X),
    .GRID_Y    (GRID_Y),
    .GRID_Z    (GRID_Z),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_cand_x     (in_cand_x),
    .in_cand_y     (in_cand_y),
    .in_cand_z     (in_cand_z),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_cell_addr (out_cell_addr),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) occupancy.match_result(out_status, out_cell_addr);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL poisson_disk_grid_accept_unit");
        $finish;
      end
    end
  end

  // start stays high from one word to the next unless a gap is taken
  task automatic send_word(logic cmd, logic [pdga_pkg::COORD_W-1:0] x,
                           logic [pdga_pkg::COORD_W-1:0] y,
                           logic [pdga_pkg::COORD_W-1:0] z);
    while (sender_gaps && $urandom_range(99) < 21) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_cand_x <= x;
    in_cand_y <= y;
    in_cand_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    occupancy.take_word(cmd, x, y, z);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (occupancy.pending_verdicts.size() != 0 || busy);
  endtask

  task automatic write_reg(logic [pdga_pkg::CFG_IDX_W-1:0] idx,
                           logic [pdga_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    occupancy.set_reg(idx, data);
  endtask

  // extents carry random junk above bit 14; sometimes also hit an unused index
  task automatic load_regs(logic [pdga_pkg::COORD_W-1:0] ex, logic [pdga_pkg::COORD_W-1:0] ey,
                           logic [pdga_pkg::COORD_W-1:0] ez,
                           logic [pdga_pkg::RADSQ_W-1:0] rsq);
    logic [pdga_pkg::CFG_DATA_W-1:0] data;
    data = pdga_pkg::CFG_DATA_W'($urandom);
    data[pdga_pkg::COORD_W-1:0] = ex;
    write_reg(pdga_pkg::REG_EXTENT_X, data);
    data = pdga_pkg::CFG_DATA_W'($urandom);
    data[pdga_pkg::COORD_W-1:0] = ey;
    write_reg(pdga_pkg::REG_EXTENT_Y, data);
    data = pdga_pkg::CFG_DATA_W'($urandom);
    data[pdga_pkg::COORD_W-1:0] = ez;
    write_reg(pdga_pkg::REG_EXTENT_Z, data);
    write_reg(pdga_pkg::REG_RADIUS_SQ, rsq);
    if ($urandom_range(1))
      write_reg(pdga_pkg::CFG_IDX_W'(pdga_pkg::REG_RADIUS_SQ + 1 + $urandom_range(3)),
                pdga_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_center(int cells);
    int r;
    r = int'($urandom_range(9));
    if (r < 2) return 0;
    if (r < 4) return cells - 1;
    return int'($urandom_range(cells - 1));
  endfunction

  function automatic logic [pdga_pkg::COORD_W-1:0] near_coord(int center, int cells);
    int c;
    c = center + int'($urandom_range(4)) - 2;
    if (c < 0) c = 0;
    if (c > cells - 1) c = cells - 1;
    return pdga_pkg::COORD_W'((c << FRAC_BITS) + int'($urandom_range((1 << FRAC_BITS) - 1)));
  endfunction

  function automatic logic [pdga_pkg::COORD_W-1:0] pick_extent(int center);
    int r;
    int e;
    r = int'($urandom_range(99));
    if (r < 60) return COORD_MAX;
    if (r < 64) return '0;
    if (r < 82) begin
      // bound cutting through the cluster
      e = ((center + 1) << FRAC_BITS) - int'($urandom_range(2 << FRAC_BITS));
      if (e < 0) e = 0;
      if (e > int'(COORD_MAX)) e = int'(COORD_MAX);
      return pdga_pkg::COORD_W'(e);
    end
    return pdga_pkg::COORD_W'($urandom);
  endfunction

  function automatic logic [pdga_pkg::RADSQ_W-1:0] pick_radius();
    int r;
    r = int'($urandom_range(99));
    if (r < 10) return '0;
    if (r < 20) return RADSQ_MAX;
    if (r < 40) return pdga_pkg::RADSQ_W'($urandom);
    return pdga_pkg::RADSQ_W'($urandom_range(1 << (2 * FRAC_BITS), 5 << (2 * FRAC_BITS)));
  endfunction

  initial begin
    int cx, cy, cz;
    int clear_at;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // reset sweeps the grid; wait it out before touching anything
    do @(posedge clk); while (busy !== 1'b0);

    // reset settings: full extent, spacing sqrt(3) cells
    send_word(CMD_TEST, 0, 0, 0);
    send_word(CMD_TEST, COORD_MAX, COORD_MAX, COORD_MAX);
    send_word(CMD_TEST, 32766, 32766, 32766);
    send_word(CMD_TEST, 1024, 0, 0);
    send_word(CMD_TEST, 2047, 2047, 2047);
    send_word(CMD_TEST, 3071, 3071, 3071);
    send_word(CMD_TEST, 3070, 3071, 3071);
    send_word(CMD_CLEAR, pdga_pkg::COORD_W'($urandom), pdga_pkg::COORD_W'($urandom),
              pdga_pkg::COORD_W'($urandom));
    send_word(CMD_TEST, 3070, 3071, 3071);
    wait_for_results();

    load_regs('0, COORD_MAX, COORD_MAX, '0);
    send_word(CMD_TEST, 0, 0, 0);
    send_word(CMD_TEST, pdga_pkg::COORD_W'($urandom), pdga_pkg::COORD_W'($urandom),
              pdga_pkg::COORD_W'($urandom));
    wait_for_results();

    load_regs(5000, 9000, 12000, '0);
    send_word(CMD_TEST, 4999, 8999, 11999);
    send_word(CMD_TEST, 5000, 100, 100);
    send_word(CMD_TEST, 100, 9000, 100);
    send_word(CMD_TEST, 100, 100, 12000);
    send_word(CMD_TEST, 4999, 8999, 11999);
    wait_for_results();

    load_regs(COORD_MAX, COORD_MAX, COORD_MAX, RADSQ_MAX);
    send_word(CMD_TEST, 0, 0, 0);
    send_word(CMD_TEST, 10240, 10240, 10240);
    send_word(CMD_TEST, 12287, 12287, 12287);
    send_word(CMD_TEST, 16384, 10240, 10240);

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_for_results();
      cx = pick_center(GRID_X);
      cy = pick_center(GRID_Y);
      cz = pick_center(GRID_Z);
      load_regs(pick_extent(cx), pick_extent(cy), pick_extent(cz), pick_radius());
      sender_gaps = !(p == 6 || p == 7);
      // a clear sweeps the whole grid, so keep them few
      clear_at = (p == 4 || p == 9 || p == 13) ? int'($urandom_range(WORDS_PER_PHASE - 1)) : -1;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n == clear_at)
          send_word(CMD_CLEAR, pdga_pkg::COORD_W'($urandom), pdga_pkg::COORD_W'($urandom),
                    pdga_pkg::COORD_W'($urandom));
        else if ($urandom_range(99) < 10)
          send_word(CMD_TEST, pdga_pkg::COORD_W'($urandom), pdga_pkg::COORD_W'($urandom),
                    pdga_pkg::COORD_W'($urandom));
        else
          send_word(CMD_TEST, near_coord(cx, GRID_X), near_coord(cy, GRID_Y),
                    near_coord(cz, GRID_Z));
        if (p == 2 && n == WORDS_PER_PHASE / 2) wait_for_results();
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (occupancy.errors == 0) begin
      $display("PASS poisson_disk_grid_accept_unit");
    end else begin
      $display("FAIL poisson_disk_grid_accept_unit");
    end
    $finish;
  end

endmodule
